>>> hw/rtl/lfc_pkg.sv
package lfc_pkg;

  localparam int MAX_TAPS_DEF    = 1024;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int ACC_BITS        = 64;
  localparam int COUNT_BITS      = 11;
  localparam int INDEX_BITS      = 10;

  localparam logic [1:0] OP_FEED  = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_PUSH
  } state_t;

  typedef struct packed {
    logic coef_wr;
    logic hist_clr;
    logic feed_start;
    logic bypass_load;
    logic issue;
    logic round;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic bypass;
    logic last_tap;
    logic pipe_busy;
    logic out_busy;
  } sts_t;

  localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

  // add that clips at the signed accumulator range
  function automatic logic signed [ACC_BITS-1:0] sat_add(
    input logic signed [ACC_BITS-1:0] a,
    input logic signed [ACC_BITS-1:0] b
  );
    logic signed [ACC_BITS:0] s;
    s = (ACC_BITS+1)'(a) + (ACC_BITS+1)'(b);
    if (s[ACC_BITS] != s[ACC_BITS-1]) begin
      return s[ACC_BITS] ? ACC_MIN : ACC_MAX;
    end
    return s[ACC_BITS-1:0];
  endfunction

endpackage

>>> hw/rtl/long_fir_convolution.sv
// Direct-form FIR convolution of a sample stream with a loaded impulse response,
// one multiply-accumulate per cycle through a single shared multiplier. A feed
// with N taps in use (N = tap count, capped at MAX_TAPS) keeps the input closed
// while the coefficient and history memories are stepped one read per tap, the
// pipeline drains, the sum is rounded and the result is handed off into the
// output register. With a tap count of zero the sample passes straight through
// to the output register. Tap loads, history clears and unused opcodes leave
// the block idle. A history clear (also done by reset and by every tap count
// write) only resets the write pointer and a fill count, so there is no
// clearing pass. The output register lets the next item in while a result
// still waits. Coefficients read before being loaded are undefined.
module long_fir_convolution #(
  parameter int MAX_TAPS    = lfc_pkg::MAX_TAPS_DEF,
  parameter int SAMPLE_BITS = lfc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       in_opcode,
  input  logic signed [SAMPLE_BITS-1:0]    in_sample,
  input  logic [lfc_pkg::INDEX_BITS-1:0]   in_tap_index,
  input  logic signed [SAMPLE_BITS-1:0]    in_tap_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [SAMPLE_BITS-1:0]    out_sample,
  input  logic                             cfg_wr_en,
  input  logic [lfc_pkg::COUNT_BITS-1:0]   cfg_wr_data
);

  lfc_pkg::cmd_t cmd;
  lfc_pkg::sts_t sts;

  lfc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lfc_dp #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_sample    (in_sample),
    .in_tap_index (in_tap_index),
    .in_tap_value (in_tap_value),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_sample   (out_sample)
  );

endmodule

>>> hw/rtl/lfc_ctrl.sv
module lfc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [1:0]    in_opcode,
  output logic          in_ready,
  input  lfc_pkg::sts_t sts,
  output lfc_pkg::cmd_t cmd
);

  lfc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lfc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      lfc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_opcode)
            lfc_pkg::OP_FEED: begin
              if (sts.bypass) begin
                cmd.bypass_load = 1'b1;
                state_nxt       = lfc_pkg::ST_PUSH;
              end else begin
                cmd.feed_start = 1'b1;
                state_nxt      = lfc_pkg::ST_RUN;
              end
            end
            lfc_pkg::OP_LOAD:  cmd.coef_wr  = 1'b1;
            lfc_pkg::OP_CLEAR: cmd.hist_clr = 1'b1;
            default: ;
          endcase
        end
      end
      lfc_pkg::ST_RUN: begin
        cmd.issue = 1'b1;
        if (sts.last_tap) begin
          state_nxt = lfc_pkg::ST_DRAIN;
        end
      end
      lfc_pkg::ST_DRAIN: begin
        // wait for the last product to land in the accumulator
        if (!sts.pipe_busy) begin
          cmd.round = 1'b1;
          state_nxt = lfc_pkg::ST_PUSH;
        end
      end
      lfc_pkg::ST_PUSH: begin
        if (!sts.out_busy) begin
          cmd.push  = 1'b1;
          state_nxt = lfc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lfc_pkg::ST_IDLE;
    endcase
  end

endmodule

>>> hw/rtl/lfc_dp.sv
module lfc_dp #(
  parameter int MAX_TAPS    = lfc_pkg::MAX_TAPS_DEF,
  parameter int SAMPLE_BITS = lfc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  lfc_pkg::cmd_t                       cmd,
  output lfc_pkg::sts_t                       sts,
  input  logic signed [SAMPLE_BITS-1:0]       in_sample,
  input  logic [lfc_pkg::INDEX_BITS-1:0]      in_tap_index,
  input  logic signed [SAMPLE_BITS-1:0]       in_tap_value,
  input  logic                                cfg_wr_en,
  input  logic [lfc_pkg::COUNT_BITS-1:0]      cfg_wr_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [SAMPLE_BITS-1:0]       out_sample
);

  localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int KW = $clog2(MAX_TAPS + 1);
  localparam int PW = 2 * SAMPLE_BITS;
  localparam int NB = lfc_pkg::ACC_BITS;
  localparam logic [AW-1:0] LAST_POS = AW'(MAX_TAPS - 1);
  localparam logic [KW-1:0] DEPTH    = KW'(MAX_TAPS);
  localparam logic signed [NB-1:0] RND    = 64'sd1 <<< (SAMPLE_BITS - 2);
  localparam logic signed [NB-1:0] OUT_HI = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
  localparam logic signed [NB-1:0] OUT_LO = -OUT_HI - 64'sd1;

  logic [lfc_pkg::COUNT_BITS-1:0] tap_count_r;
  logic [AW-1:0]                  wp_r, wp_nxt, pos_r, pos_nxt;
  logic [KW-1:0]                  fill_r, k_r, taps;

  logic signed [SAMPLE_BITS-1:0] coef_mem_r [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] hist_mem_r [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] coef_rd_r, hist_rd_r;
  logic                          hv_r;
  logic                          v1_r, v2_r;
  logic signed [PW-1:0]          prod_r;
  logic signed [NB-1:0]          acc_r, rnd_sum, shifted;
  logic [SAMPLE_BITS-1:0]        res_r, res_nxt;
  logic                          out_valid_r;
  logic [SAMPLE_BITS-1:0]        out_sample_r;

  assign taps    = (32'(tap_count_r) > MAX_TAPS) ? DEPTH : KW'(tap_count_r);
  assign wp_nxt  = (wp_r == LAST_POS) ? '0 : wp_r + AW'(1);
  assign pos_nxt = (pos_r == '0) ? LAST_POS : pos_r - AW'(1);

  // history is only ever filled from position zero after a clear, so a fill
  // count says which entries hold real samples
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= '0;
      wp_r        <= '0;
      fill_r      <= '0;
    end else if (cfg_wr_en) begin
      tap_count_r <= cfg_wr_data;
      wp_r        <= '0;
      fill_r      <= '0;
    end else if (cmd.hist_clr) begin
      wp_r   <= '0;
      fill_r <= '0;
    end else if (cmd.feed_start) begin
      wp_r <= wp_nxt;
      if (fill_r < DEPTH) begin
        fill_r <= fill_r + KW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.coef_wr && (32'(in_tap_index) < MAX_TAPS)) begin
      coef_mem_r[AW'(in_tap_index)] <= in_tap_value;
    end
    if (cmd.feed_start) begin
      hist_mem_r[wp_r] <= in_sample;
    end
    coef_rd_r <= coef_mem_r[k_r[AW-1:0]];
    hist_rd_r <= hist_mem_r[pos_r];
    hv_r      <= (KW'(pos_r) < fill_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.feed_start) begin
      k_r   <= '0;
      pos_r <= wp_r;
    end else if (cmd.issue) begin
      k_r   <= k_r + KW'(1);
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= hv_r ? (PW'(coef_rd_r) * PW'(hist_rd_r)) : '0;
    if (cmd.feed_start) begin
      acc_r <= '0;
    end else if (v2_r) begin
      acc_r <= lfc_pkg::sat_add(acc_r, NB'(prod_r));
    end
  end

  // round to nearest, ties up, then clip to the sample range
  always_comb begin
    rnd_sum = lfc_pkg::sat_add(acc_r, RND);
    shifted = rnd_sum >>> (SAMPLE_BITS - 1);
    if (shifted > OUT_HI) begin
      res_nxt = OUT_HI[SAMPLE_BITS-1:0];
    end else if (shifted < OUT_LO) begin
      res_nxt = OUT_LO[SAMPLE_BITS-1:0];
    end else begin
      res_nxt = shifted[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.bypass_load) begin
      res_r <= in_sample;
    end else if (cmd.round) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_sample_r <= res_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

  assign sts.bypass    = (tap_count_r == '0);
  assign sts.last_tap  = (k_r == taps - KW'(1));
  assign sts.pipe_busy = v1_r | v2_r;
  assign sts.out_busy  = out_valid_r & ~out_ready;

endmodule

>>> hw/rtl/lfc_checker.sv
module lfc_checker #(
  parameter int SAMPLE_BITS = lfc_pkg::SAMPLE_BITS_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic [1:0]             in_opcode,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SAMPLE_BITS-1:0] out_sample
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk)
    rst_n && out_valid && !out_ready |=> out_valid && $stable(out_sample))
    else $error("result changed while stalled");

  // a feed closes the input once it is taken
  a_feed_busy: assert property (@(posedge clk)
    rst_n && in_valid && in_ready && in_opcode == lfc_pkg::OP_FEED |=> !in_ready)
    else $error("input open right after a feed transfer");

  // loads and clears finish in the cycle they are taken
  a_load_quick: assert property (@(posedge clk)
    rst_n && in_valid && in_ready &&
    (in_opcode == lfc_pkg::OP_LOAD || in_opcode == lfc_pkg::OP_CLEAR) |=> in_ready)
    else $error("input closed after a load or clear");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind long_fir_convolution lfc_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_lfc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .in_opcode  (in_opcode),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_sample (out_sample)
);
